// ===== design/docc_pkg.sv =====
// Shared constants and types for the door open/close controller.
package docc_pkg;

  // Countdown width; loads from 16-bit fields saturate to this width.
  localparam int unsigned TIMER_W = 16;
  typedef logic [TIMER_W-1:0] timer_t;
  localparam timer_t TIMER_MAX = {TIMER_W{1'b1}};

  // Event opcodes.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_OPEN   = 3'd1,
    OP_CLOSE  = 3'd2,
    OP_LOCK   = 3'd3,
    OP_OBST   = 3'd4
  } opcode_t;

  // Codes reported for the state entered.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_LOCKED  = 3'd1;
  localparam logic [2:0] EV_OPENED  = 3'd2;
  localparam logic [2:0] EV_CLOSING = 3'd3;
  localparam logic [2:0] EV_BLOCKED = 3'd4;

  // Config register indexes (byte address 4*i).
  localparam logic REG_CLOSING = 1'b0;
  localparam logic REG_BLOCKED = 1'b1;

  localparam logic [15:0] CLOSING_RESET = 16'd1200;
  localparam logic [15:0] BLOCKED_RESET = 16'd1000;

  // Saturating load of a 16-bit tick count into the countdown.
  function automatic timer_t sat_load(logic [15:0] n);
    logic [32:0] wide;
    wide = 33'(n);
    if (wide > 33'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return timer_t'(wide);
  endfunction

endpackage

// ===== design/docc_if.sv =====
// Event and result channel interfaces for the door open/close controller.
interface docc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] hold_ticks;
  logic        obstacle_value;

  modport source (output valid, output opcode, output hold_ticks, output obstacle_value,
                  input ready);
  modport sink   (input valid, input opcode, input hold_ticks, input obstacle_value,
                  output ready);
endinterface

interface docc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] door_state;
  logic [2:0] event_code;
  logic       close_failed;
  logic       obstacle_changed;
  logic       obstacle_now;

  modport source (output valid, output door_state, output event_code, output close_failed,
                  output obstacle_changed, output obstacle_now, input ready);
  modport sink   (input valid, input door_state, input event_code, input close_failed,
                  input obstacle_changed, input obstacle_now, output ready);
endinterface

// ===== design/door_open_close_controller_unit.sv =====
// Door open/close controller top level: event decode, countdown and result register.
//
// Usage:
//   req  - one event per beat: tick, open request (with hold_ticks), close
//          request, lock, or obstacle update (with obstacle_value).
//   rsp  - exactly one result beat per event: state after the event, state
//          entered, close-failed flag and obstacle level/change flags.
//   APB  - closing_ticks at 0x0, blocked_ticks at 0x4 (low 16 bits of pwdata).
//          Write at psel & penable & pwrite; pready tied high, reads return
//          the register zero-extended.
// Each event's result is registered and shows on rsp in the cycle after its req beat.
// Throughput: one event per cycle while results are taken. The whole update is a single pass of
//   shallow logic from the accepted beat into the state and result registers;
//   the single result register is what paces the channel.
// Stall: req.ready stays high while the result register is empty or being
//   taken in the same cycle; a held result blocks only further events.
// Reset (rst, synchronous): door locked, no countdown, hold length and
//   obstacle level zero, registers back to 1200 and 1000, rsp empty.
module door_open_close_controller_unit
  import docc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  docc_req_if.sink     req,
  docc_rsp_if.source   rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [1:0] {
    ST_LOCKED  = 2'd0,
    ST_OPEN    = 2'd1,
    ST_CLOSING = 2'd2,
    ST_BLOCKED = 2'd3
  } state_t;

  // Config registers
  logic [15:0] closing_ticks;
  logic [15:0] blocked_ticks;

  // Door state
  state_t      state, state_next;
  timer_t      countdown, countdown_next;
  logic        timer_running, timer_running_next;
  logic [15:0] hold_length, hold_length_next;
  logic        obstacle_level, obstacle_level_next;

  // Result of the beat being taken
  logic [2:0]  ev;
  logic        failed;
  logic        changed;

  // Output register
  logic        rsp_valid;
  logic [1:0]  rsp_state;
  logic [2:0]  rsp_event;
  logic        rsp_failed;
  logic        rsp_changed;
  logic        rsp_obstacle;

  logic        req_fire;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = (paddr[2] == REG_BLOCKED) ? {16'd0, blocked_ticks} : {16'd0, closing_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      closing_ticks <= CLOSING_RESET;
      blocked_ticks <= BLOCKED_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BLOCKED) begin
        blocked_ticks <= pwdata[15:0];
      end else begin
        closing_ticks <= pwdata[15:0];
      end
    end
  end

  // Free to take a beat unless a result is held and not being drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  // Single-pass event update
  always_comb begin
    state_next          = state;
    countdown_next      = countdown;
    timer_running_next  = timer_running;
    hold_length_next    = hold_length;
    obstacle_level_next = obstacle_level;
    ev                  = EV_NONE;
    failed              = 1'b0;
    changed             = 1'b0;

    case (req.opcode)
      OP_TICK: begin
        if (timer_running) begin
          if (countdown <= timer_t'(1)) begin
            countdown_next     = '0;
            timer_running_next = 1'b0;
            case (state)
              ST_BLOCKED: begin
                state_next         = ST_OPEN;
                countdown_next     = sat_load(hold_length);
                timer_running_next = 1'b1;
                ev                 = EV_OPENED;
              end
              ST_OPEN, ST_CLOSING: begin
                if (obstacle_level) begin
                  state_next         = ST_BLOCKED;
                  countdown_next     = sat_load(blocked_ticks);
                  timer_running_next = 1'b1;
                  ev                 = EV_BLOCKED;
                  failed             = 1'b1;
                end else if (state == ST_OPEN) begin
                  state_next         = ST_CLOSING;
                  countdown_next     = sat_load(closing_ticks);
                  timer_running_next = 1'b1;
                  ev                 = EV_CLOSING;
                end else begin
                  state_next = ST_LOCKED;
                  ev         = EV_LOCKED;
                end
              end
              default: begin
              end
            endcase
          end else begin
            countdown_next = countdown - timer_t'(1);
          end
        end
      end
      OP_OPEN: begin
        // Always ends up open with the hold restarted; only an entry reports
        hold_length_next   = req.hold_ticks;
        state_next         = ST_OPEN;
        countdown_next     = sat_load(req.hold_ticks);
        timer_running_next = 1'b1;
        ev                 = (state == ST_OPEN) ? EV_NONE : EV_OPENED;
      end
      OP_CLOSE: begin
        if (state != ST_LOCKED) begin
          if (obstacle_level) begin
            failed = 1'b1;
            if (state == ST_BLOCKED) begin
              // already blocked: hold stops, door stays put
              timer_running_next = 1'b0;
            end else begin
              state_next         = ST_BLOCKED;
              countdown_next     = sat_load(blocked_ticks);
              timer_running_next = 1'b1;
              ev                 = EV_BLOCKED;
            end
          end else if (state != ST_CLOSING) begin
            state_next         = ST_CLOSING;
            countdown_next     = sat_load(closing_ticks);
            timer_running_next = 1'b1;
            ev                 = EV_CLOSING;
          end
        end
      end
      OP_LOCK: begin
        if (state != ST_LOCKED) begin
          state_next         = ST_LOCKED;
          countdown_next     = '0;
          timer_running_next = 1'b0;
          ev                 = EV_LOCKED;
        end
      end
      OP_OBST: begin
        if (req.obstacle_value != obstacle_level) begin
          obstacle_level_next = req.obstacle_value;
          changed             = 1'b1;
          if (state == ST_CLOSING && req.obstacle_value) begin
            state_next         = ST_BLOCKED;
            countdown_next     = sat_load(blocked_ticks);
            timer_running_next = 1'b1;
            ev                 = EV_BLOCKED;
            failed             = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOCKED;
      countdown      <= '0;
      timer_running  <= 1'b0;
      hold_length    <= '0;
      obstacle_level <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (req_fire) begin
        state          <= state_next;
        countdown      <= countdown_next;
        timer_running  <= timer_running_next;
        hold_length    <= hold_length_next;
        obstacle_level <= obstacle_level_next;
        rsp_valid      <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_state    <= state_next;
      rsp_event    <= ev;
      rsp_failed   <= failed;
      rsp_changed  <= changed;
      rsp_obstacle <= obstacle_level_next;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.door_state       = rsp_state;
  assign rsp.event_code       = rsp_event;
  assign rsp.close_failed     = rsp_failed;
  assign rsp.obstacle_changed = rsp_changed;
  assign rsp.obstacle_now     = rsp_obstacle;

  // Locked door never has a countdown going
  a_locked_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOCKED |-> !timer_running)
    else $error("timer running while locked");

  // Open door always has its hold running
  a_open_timed: assert property (@(posedge clk) disable iff (rst)
    state == ST_OPEN |-> timer_running)
    else $error("open without hold timer");

  // Every accepted event leaves a result in the register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp_valid)
    else $error("accepted event produced no result");

  // A refused close always leaves the door blocked
  a_fail_blocked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_failed |-> rsp_state == ST_BLOCKED)
    else $error("close_failed without blocked state");

  // An opened event reports the open state
  a_opened_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_event == EV_OPENED |-> rsp_state == ST_OPEN)
    else $error("opened event with wrong state");

endmodule

// ===== test/tb_door_open_close_controller_unit.sv =====
// Self-checking testbench for the door open/close controller: directed table, then random events.
`timescale 1ns / 1ps

module tb_door_open_close_controller_unit
  import docc_pkg::*;
();

  // Door states as reported on rsp.door_state.
  typedef enum logic [1:0] {
    DS_LOCKED  = 2'd0,
    DS_OPEN    = 2'd1,
    DS_CLOSING = 2'd2,
    DS_BLOCKED = 2'd3
  } door_t;

  // Opcodes past OP_OBST carry no meaning and must leave everything alone.
  localparam logic [2:0] OP_RSV_LO = 3'd5;
  localparam logic [2:0] OP_RSV_HI = 3'd7;

  // Cycles with no beat on either channel before the run is declared hung. The worst
  // honest quiet stretch is a long receiver hold-off plus a long sender gap plus an
  // APB burst.
  localparam int IDLE_LIMIT    = 2000;
  localparam int SQUEEZE_LEN   = 100;
  localparam int N_DIR         = 25;
  localparam int N_PHASE       = 6;
  localparam int ITEMS_PER_PH  = 170;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] hold;
    logic        obs;
  } door_item_t;

  typedef struct packed {
    logic [1:0] door_state;
    logic [2:0] event_code;
    logic       close_failed;
    logic       obstacle_changed;
    logic       obstacle_now;
  } door_res_t;

  // One row of the directed table; 'typed' rows carry their own expected result.
  typedef struct packed {
    door_item_t it;
    bit         typed;
    door_res_t  want;
  } door_row_t;

  localparam door_res_t QUIET_LOCKED = '{DS_LOCKED, EV_NONE, 1'b0, 1'b0, 1'b0};
  localparam door_res_t JUST_OPENED  = '{DS_OPEN, EV_OPENED, 1'b0, 1'b0, 1'b0};
  localparam door_res_t FROM_MODEL   = '0;

  logic clk;
  logic rst;

  docc_req_if req_ch ();
  docc_rsp_if rsp_ch ();

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  door_open_close_controller_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Door model: its own copy of state and timing registers, advanced once per
  // accepted event beat.
  // ---------------------------------------------------------------------------
  door_t       door_st;
  timer_t      tmr_cnt;
  logic        tmr_on;
  logic [15:0] hold_len;
  logic        obst_lvl;
  logic [15:0] cfg_closing;
  logic [15:0] cfg_blocked;

  // Results still owed by the DUT, oldest first.
  door_res_t   owed_results [$];

  int          errors;
  int          idle_cycles;
  bit          steady;        // no gaps on either side while set
  bit          squeeze_req;   // receiver to hold off for a long stretch
  door_row_t   dir_rows [N_DIR];
  door_res_t   got_r;
  door_res_t   want_r;

  int unsigned ph_closing [N_PHASE] = '{1, 2, 65535, 12, 1200, 5};
  int unsigned ph_blocked [N_PHASE] = '{1, 7, 65535, 1, 1000, 65535};

  function automatic void load_timer(logic [15:0] n);
    tmr_cnt = (32'(n) > 32'(TIMER_MAX)) ? TIMER_MAX : timer_t'(n);
    tmr_on  = 1'b1;
  endfunction

  // Move to state s; a move to the state already held reports nothing.
  function automatic logic [2:0] enter_door(door_t s);
    if (door_st == s) begin
      return EV_NONE;
    end
    door_st = s;
    case (s)
      DS_LOCKED: begin
        tmr_on  = 1'b0;
        tmr_cnt = '0;
        return EV_LOCKED;
      end
      DS_OPEN: begin
        load_timer(hold_len);
        return EV_OPENED;
      end
      DS_CLOSING: begin
        load_timer(cfg_closing);
        return EV_CLOSING;
      end
      default: begin
        load_timer(cfg_blocked);
        return EV_BLOCKED;
      end
    endcase
  endfunction

  function automatic door_res_t predict_door(door_item_t it);
    door_res_t  r;
    logic [2:0] ev;
    logic       failed;
    logic       changed;
    ev      = EV_NONE;
    failed  = 1'b0;
    changed = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        if (tmr_on) begin
          if (tmr_cnt <= 1) begin
            tmr_cnt = '0;
            tmr_on  = 1'b0;
            if (door_st == DS_BLOCKED) begin
              ev = enter_door(DS_OPEN);
            end else if (door_st == DS_OPEN || door_st == DS_CLOSING) begin
              // expiry with something in the way: refuse to close
              if (obst_lvl) begin
                ev     = enter_door(DS_BLOCKED);
                failed = 1'b1;
              end else begin
                ev = enter_door(door_st == DS_OPEN ? DS_CLOSING : DS_LOCKED);
              end
            end
          end else begin
            tmr_cnt = tmr_cnt - 1'b1;
          end
        end
      end
      OP_OPEN: begin
        hold_len = it.hold;
        if (door_st == DS_OPEN) begin
          load_timer(hold_len);   // restart the hold, nothing entered
        end else begin
          tmr_on = 1'b0;
          ev     = enter_door(DS_OPEN);
        end
      end
      OP_CLOSE: begin
        if (door_st != DS_LOCKED) begin
          if (obst_lvl) begin
            // when already blocked this just stops the blocked hold
            if (door_st != DS_CLOSING) begin
              tmr_on = 1'b0;
            end
            ev     = enter_door(DS_BLOCKED);
            failed = 1'b1;
          end else if (door_st != DS_CLOSING) begin
            ev = enter_door(DS_CLOSING);
          end
        end
      end
      OP_LOCK: begin
        ev = enter_door(DS_LOCKED);
      end
      OP_OBST: begin
        if (it.obs != obst_lvl) begin
          obst_lvl = it.obs;
          changed  = 1'b1;
          if (door_st == DS_CLOSING && obst_lvl) begin
            ev     = enter_door(DS_BLOCKED);
            failed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.door_state       = door_st;
    r.event_code       = ev;
    r.close_failed     = failed;
    r.obstacle_changed = changed;
    r.obstacle_now     = obst_lvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking helpers
  // ---------------------------------------------------------------------------
  task automatic report(string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Weighted random event. Ticks dominate so that countdowns run out; hold times
  // are mostly tiny so open holds expire, with full-range values mixed in.
  function automatic door_item_t random_event();
    door_item_t it;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.opcode = OP_TICK;
    end else if (r < 58) begin
      it.opcode = OP_OPEN;
    end else if (r < 70) begin
      it.opcode = OP_CLOSE;
    end else if (r < 76) begin
      it.opcode = OP_LOCK;
    end else if (r < 94) begin
      it.opcode = OP_OBST;
    end else begin
      it.opcode = 3'($urandom_range(OP_RSV_LO, OP_RSV_HI));
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      it.hold = 16'($urandom_range(0, 6));
    end else if (r == 7) begin
      it.hold = 16'($urandom);
    end else if (r == 8) begin
      it.hold = 16'hFFFF;
    end else begin
      it.hold = '0;
    end
    // obstacle updates usually flip the level, sometimes repeat it
    if (it.opcode == OP_OBST) begin
      it.obs = ($urandom_range(0, 3) == 0) ? obst_lvl : ~obst_lvl;
    end else begin
      it.obs = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender: optional gap, then hold the beat until it is taken. The model
  // is stepped at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(door_item_t it, bit typed, door_res_t want);
    door_res_t pred;
    int        gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= it.opcode;
    req_ch.hold_ticks     <= it.hold;
    req_ch.obstacle_value <= it.obs;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    pred = predict_door(it);
    owed_results.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait for every owed result so that the block is left quiet.
  task automatic drain_events();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup then access phase; write lands on the access edge with pready.
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] reg_addr(logic idx);
    return {idx, 2'b00};
  endfunction

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_check(logic idx, logic [15:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, reg_addr(idx), '0, rd);
    check_field(idx == REG_CLOSING ? "closing_ticks" : "blocked_ticks", rd, 32'(want));
  endtask

  // Only ever called with the block idle. Upper pwdata bits are junk on purpose.
  task automatic set_timing(logic [15:0] closing, logic [15:0] blocked);
    logic [31:0] rd;
    apb_xfer(1'b1, reg_addr(REG_CLOSING), {16'($urandom), closing}, rd);
    cfg_closing = closing;
    apb_xfer(1'b1, reg_addr(REG_BLOCKED), {16'($urandom), blocked}, rd);
    cfg_blocked = blocked;
    read_check(REG_CLOSING, closing);
    read_check(REG_BLOCKED, blocked);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready toggles at falling edges, with random hold-offs and
  // one long squeeze on request so the result register fills and req stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        n = SQUEEZE_LEN;
      end else begin
        n = pick_gap();
      end
      repeat (n) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge (pre-update values).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want_r = owed_results.pop_front();
          got_r  = '{rsp_ch.door_state, rsp_ch.event_code, rsp_ch.close_failed,
                     rsp_ch.obstacle_changed, rsp_ch.obstacle_now};
          check_field("door_state", got_r.door_state, want_r.door_state);
          check_field("event_code", got_r.event_code, want_r.event_code);
          check_field("close_failed", got_r.close_failed, want_r.close_failed);
          check_field("obstacle_changed", got_r.obstacle_changed, want_r.obstacle_changed);
          check_field("obstacle_now", got_r.obstacle_now, want_r.obstacle_now);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         n_real;
    door_item_t it;

    // everything driven from time zero
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_TICK;
    req_ch.hold_ticks     = '0;
    req_ch.obstacle_value = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    errors                = 0;
    idle_cycles           = 0;
    steady                = 1'b0;
    squeeze_req           = 1'b0;

    door_st     = DS_LOCKED;
    tmr_cnt     = '0;
    tmr_on      = 1'b0;
    hold_len    = '0;
    obst_lvl    = 1'b0;
    cfg_closing = CLOSING_RESET;
    cfg_blocked = BLOCKED_RESET;

    // Directed walk with both timings at their shortest, so every closing and blocked
    // countdown runs out on the next tick. Obstacle level starts clear.
    dir_rows = '{
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b1, QUIET_LOCKED},  // tick, nothing running
      '{'{OP_CLOSE,  16'h0000, 1'b0}, 1'b1, QUIET_LOCKED},  // close while locked
      '{'{OP_LOCK,   16'h0000, 1'b0}, 1'b1, QUIET_LOCKED},  // lock while locked
      '{'{OP_RSV_HI, 16'hFFFF, 1'b1}, 1'b1, QUIET_LOCKED},  // spare opcodes ignored
      '{'{OP_RSV_LO, 16'h0000, 1'b0}, 1'b1, QUIET_LOCKED},
      '{'{OP_OPEN,   16'h0000, 1'b0}, 1'b1, JUST_OPENED},   // zero hold
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // hold out -> closing
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // travel out -> locked
      '{'{OP_OPEN,   16'hFFFF, 1'b0}, 1'b1, JUST_OPENED},   // longest hold
      '{'{OP_OPEN,   16'h0003, 1'b0}, 1'b0, FROM_MODEL},    // re-open restarts hold
      '{'{OP_TICK,   16'h0000, 1'b1}, 1'b0, FROM_MODEL},
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},
      '{'{OP_OBST,   16'h0000, 1'b1}, 1'b0, FROM_MODEL},    // obstacle while open
      '{'{OP_OBST,   16'hFFFF, 1'b1}, 1'b0, FROM_MODEL},    // same level again
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // hold out, blocked
      '{'{OP_CLOSE,  16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // close while blocked
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // nothing running now
      '{'{OP_OBST,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // obstacle clears
      '{'{OP_CLOSE,  16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // blocked -> closing
      '{'{OP_CLOSE,  16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // close while closing
      '{'{OP_OBST,   16'h0000, 1'b1}, 1'b0, FROM_MODEL},    // obstacle mid-travel
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},    // blocked hold out -> open
      '{'{OP_CLOSE,  16'h0000, 1'b1}, 1'b0, FROM_MODEL},    // close refused
      '{'{OP_TICK,   16'h0000, 1'b0}, 1'b0, FROM_MODEL},
      '{'{OP_LOCK,   16'hFFFF, 1'b0}, 1'b0, FROM_MODEL}     // lock from open
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // registers must come out of reset at their documented values
    read_check(REG_CLOSING, CLOSING_RESET);
    read_check(REG_BLOCKED, BLOCKED_RESET);

    set_timing(16'd1, 16'd1);
    foreach (dir_rows[i]) begin
      send_event(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_events();

    // Random phases, each under its own timing; one runs with no gaps at all and
    // one opens with a long receiver squeeze while events keep coming.
    for (int ph = 0; ph < N_PHASE; ph++) begin
      set_timing(16'(ph_closing[ph]), 16'(ph_blocked[ph]));
      steady      = (ph == 1);
      squeeze_req = (ph == 3);
      n_real      = 0;
      while (n_real < ITEMS_PER_PH) begin
        it = random_event();
        if (it.opcode <= OP_OBST) begin
          n_real++;
        end
        send_event(it, 1'b0, FROM_MODEL);
      end
      drain_events();
    end

    steady = 1'b0;
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/docc_pkg.sv
design/docc_if.sv
design/door_open_close_controller_unit.sv
test/tb_door_open_close_controller_unit.sv
